[hw/rtl/alb_pkg.sv]
// Shared constants, types and register codes for the audio level bar meter.
package alb_pkg;

   // Default configuration of the strip and the block length
   localparam int LEDS_USED_DEF  = 12;
   localparam int LEDS_TOTAL_DEF = 16;
   localparam int MAX_BLOCK_DEF  = 1024;

   // Field widths
   localparam int SAMPLE_W   = 16;
   localparam int COMP_W     = 8;
   localparam int BRIGHT_W   = 7;
   localparam int LED_NUM_W  = 4;
   localparam int ENTRY_W    = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int RESULT_CAP = 16;

   // One lit LED per LEVEL_DIV of mean magnitude
   localparam int LEVEL_DIV = 1000;

   // Brightness: value * pct / 100, done as a reciprocal multiply.
   // 5243 / 2^19 is exact for every product below 25600.
   localparam int                 PROD_W      = COMP_W + BRIGHT_W;
   localparam int                 RECIP_W     = 13;
   localparam logic [RECIP_W-1:0] RECIP_MUL   = 13'd5243;
   localparam int                 RECIP_SHIFT = 19;
   localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 7'd100;

   // Input command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_COLOUR = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_METER_ENABLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS   = 1'b1;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } colour_type;

   // Scaler stage controls
   typedef struct packed {
      logic mul_en;
      logic div_en;
      logic lit;
   } scale_ctrl_type;

endpackage

[hw/rtl/alb_colour_mem.sv]
// Colour table memory with one write port, one registered read port and per-entry valid bits.
module alb_colour_mem #(
   parameter int  DEPTH = alb_pkg::LEDS_USED_DEF,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  alb_pkg::colour_type wr_data,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output alb_pkg::colour_type rd_data
);

   alb_pkg::colour_type mem [DEPTH];
   logic [DEPTH-1:0]    valid_ff;
   alb_pkg::colour_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // An entry never written since reset reads as black
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/alb_scaler.sv]
// Two-stage brightness scaler for one colour component.
module alb_scaler (
   input  logic                            clock,
   input  alb_pkg::scale_ctrl_type         ctrl,
   input  logic [alb_pkg::COMP_W-1:0]      value,
   input  logic [alb_pkg::BRIGHT_W-1:0]    bright,
   output logic [alb_pkg::COMP_W-1:0]      level
);

   localparam int WIDE_W = alb_pkg::PROD_W + alb_pkg::RECIP_W;

   logic [alb_pkg::PROD_W-1:0] prod_ff;
   logic [alb_pkg::COMP_W-1:0] level_ff;
   logic [WIDE_W-1:0]          wide;

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= alb_pkg::PROD_W'(value) * alb_pkg::PROD_W'(bright);
      end
   end

   assign wide = WIDE_W'(prod_ff) * WIDE_W'(alb_pkg::RECIP_MUL);

   // Unlit LEDs drive zero
   always_ff @(posedge clock) begin
      if (ctrl.div_en) begin
         level_ff <= ctrl.lit ?
            wide[alb_pkg::RECIP_SHIFT +: alb_pkg::COMP_W] : '0;
      end
   end

   assign level = level_ff;

endmodule

[hw/rtl/audio_level_bar_meter.sv]
// Audio level bar meter: sums sample magnitudes per block and emits one scaled colour per LED.
// A sample or colour-table write is taken whenever it is offered while req_stall is low. A
// sample carrying the block-end flag (with the meter enabled) starts a frame: a setup step,
// then per LED a colour memory read, brightness multiply, reciprocal scale and output
// register, the output held while the result side stalls; req_stall stays high for the
// whole frame. The block's sample count is never divided out:
// LED k is lit when (k+1) * 1000 * count does not exceed the block's magnitude sum,
// which equals floor(floor(sum / count) / 1000) > k. Configuration writes are always
// taken (csr_ready is tied high); a brightness above 100 saturates to 100. The colour
// table is cleared by reset through per-entry valid bits, with no clearing pass.
module audio_level_bar_meter #(
   parameter int LEDS_USED  = alb_pkg::LEDS_USED_DEF,
   parameter int LEDS_TOTAL = alb_pkg::LEDS_TOTAL_DEF,
   parameter int MAX_BLOCK  = alb_pkg::MAX_BLOCK_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // sample / colour write channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic signed [alb_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic                                req_block_end,
   input  logic [alb_pkg::ENTRY_W-1:0]         req_entry_index,
   input  logic [alb_pkg::COMP_W-1:0]          req_entry_red,
   input  logic [alb_pkg::COMP_W-1:0]          req_entry_green,
   input  logic [alb_pkg::COMP_W-1:0]          req_entry_blue,
   // LED colour channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [alb_pkg::LED_NUM_W-1:0]       rsp_led_number,
   output logic [alb_pkg::COMP_W-1:0]          rsp_out_red,
   output logic [alb_pkg::COMP_W-1:0]          rsp_out_green,
   output logic [alb_pkg::COMP_W-1:0]          rsp_out_blue,
   output logic                                rsp_frame_last,
   // configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [alb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [alb_pkg::BRIGHT_W-1:0]        csr_data
);

   localparam int IDX_W     = (LEDS_USED > 1) ? $clog2(LEDS_USED) : 1;
   localparam int CNT_W     = $clog2(MAX_BLOCK + 1);
   localparam int SUM_W     = $clog2(64'(MAX_BLOCK) * 64'd32768 + 64'd1);
   localparam int THR_W     = SUM_W + 1;
   localparam int LU_W      = 7;
   localparam int K_W       = alb_pkg::LED_NUM_W;
   localparam int FRAME_RAW = (LEDS_USED > LEDS_TOTAL) ? LEDS_USED : LEDS_TOTAL;
   localparam int FRAME_LEN = (FRAME_RAW > alb_pkg::RESULT_CAP) ?
                              alb_pkg::RESULT_CAP : FRAME_RAW;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_STEP = 6'b000010,
      S_READ = 6'b000100,
      S_MUL  = 6'b001000,
      S_DIV  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type                    state_ff, state_in;
   logic                         enable_ff, enable_in;
   logic [alb_pkg::BRIGHT_W-1:0] bright_ff, bright_in;
   logic [SUM_W-1:0]             sum_ff, sum_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [SUM_W-1:0]             frame_sum_ff, frame_sum_in;
   logic [CNT_W-1:0]             frame_cnt_ff, frame_cnt_in;
   logic [THR_W-1:0]             step_ff, step_in;
   logic [THR_W-1:0]             thr_ff, thr_in;
   logic                         lit_ok_ff, lit_ok_in;
   logic                         lit_ff, lit_in;
   logic [K_W-1:0]               k_ff, k_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [K_W-1:0]               led_num_ff, led_num_in;
   logic                         last_ff, last_in;

   logic                         req_xfer;
   logic                         rsp_xfer;
   logic                         sample_xfer;
   logic                         colour_xfer;
   logic [alb_pkg::SAMPLE_W-1:0] mag;
   logic [SUM_W-1:0]             sum_acc;
   logic [CNT_W-1:0]             cnt_acc;
   logic [THR_W-1:0]             sum_ext;
   logic [THR_W-1:0]             step_val;
   logic                         k_fits;
   logic                         lit_now;
   logic [IDX_W+K_W-1:0]         k_wide;
   logic [IDX_W+alb_pkg::ENTRY_W-1:0] wr_wide;
   logic                         wr_en;
   logic                         rd_en;
   logic [IDX_W-1:0]             rd_addr;
   alb_pkg::colour_type          wr_data;
   alb_pkg::colour_type          rd_data;
   alb_pkg::scale_ctrl_type      scale_ctrl;

   assign req_stall   = (state_ff != S_IDLE);
   assign req_xfer    = req_valid && !req_stall;
   assign rsp_xfer    = rsp_valid_ff && !rsp_stall;
   assign sample_xfer = req_xfer && (req_command == alb_pkg::CMD_SAMPLE) && enable_ff;
   assign colour_xfer = req_xfer && (req_command == alb_pkg::CMD_COLOUR);
   assign csr_ready   = 1'b1;

   // Magnitude of a two's complement sample; the most negative one gives 32768
   assign mag = req_sample_value[alb_pkg::SAMPLE_W-1] ?
                (~req_sample_value + 1'b1) : req_sample_value;

   // Add the sample unless the block is already full
   always_comb begin
      sum_acc = sum_ff;
      cnt_acc = cnt_ff;
      if (cnt_ff < CNT_W'(MAX_BLOCK)) begin
         sum_acc = sum_ff + SUM_W'(mag);
         cnt_acc = cnt_ff + 1'b1;
      end
   end

   // Colour table write port
   assign wr_wide = {{IDX_W{1'b0}}, req_entry_index};
   assign wr_en   = colour_xfer && (wr_wide < (IDX_W + alb_pkg::ENTRY_W)'(LEDS_USED));
   assign wr_data = '{red: req_entry_red, green: req_entry_green, blue: req_entry_blue};

   // LED sweep decisions
   assign k_wide   = {{IDX_W{1'b0}}, k_ff};
   assign k_fits   = ({{(LU_W - K_W){1'b0}}, k_ff} < LU_W'(LEDS_USED));
   assign rd_addr  = k_fits ? k_wide[IDX_W-1:0] : '0;
   assign rd_en    = (state_ff == S_READ);
   assign sum_ext  = {1'b0, frame_sum_ff};
   assign step_val = THR_W'(frame_cnt_ff) * THR_W'(alb_pkg::LEVEL_DIV);
   assign lit_now  = lit_ok_ff && (thr_ff <= sum_ext) && k_fits;

   always_comb begin
      state_in     = state_ff;
      enable_in    = enable_ff;
      bright_in    = bright_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      frame_sum_in = frame_sum_ff;
      frame_cnt_in = frame_cnt_ff;
      step_in      = step_ff;
      thr_in       = thr_ff;
      lit_ok_in    = lit_ok_ff;
      lit_in       = lit_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      led_num_in   = led_num_ff;
      last_in      = last_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            alb_pkg::CSR_METER_ENABLE: enable_in = csr_data[0];
            alb_pkg::CSR_BRIGHTNESS: begin
               bright_in = (csr_data > alb_pkg::BRIGHT_MAX) ? alb_pkg::BRIGHT_MAX : csr_data;
            end
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (sample_xfer) begin
               if (req_block_end) begin
                  frame_sum_in = sum_acc;
                  frame_cnt_in = cnt_acc;
                  sum_in       = '0;
                  cnt_in       = '0;
                  state_in     = S_STEP;
               end else begin
                  sum_in = sum_acc;
                  cnt_in = cnt_acc;
               end
            end
         end
         S_STEP: begin
            step_in   = step_val;
            thr_in    = step_val;
            lit_ok_in = (frame_cnt_ff != '0);
            k_in      = '0;
            state_in  = S_READ;
         end
         S_READ: begin
            // Once a threshold is missed every later LED stays dark
            lit_in = lit_now;
            if (lit_now) begin
               thr_in = thr_ff + step_ff;
            end else begin
               lit_ok_in = 1'b0;
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            rsp_valid_in = 1'b1;
            led_num_in   = k_ff;
            last_in      = (k_ff == K_W'(FRAME_LEN - 1));
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (rsp_xfer) begin
               rsp_valid_in = 1'b0;
               if (last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enable_ff    <= 1'b0;
         bright_ff    <= alb_pkg::BRIGHT_MAX;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         lit_ok_ff    <= 1'b0;
         lit_ff       <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         bright_ff    <= bright_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         lit_ok_ff    <= lit_ok_in;
         lit_ff       <= lit_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_sum_ff <= frame_sum_in;
      frame_cnt_ff <= frame_cnt_in;
      step_ff      <= step_in;
      thr_ff       <= thr_in;
      led_num_ff   <= led_num_in;
   end

   alb_colour_mem #(
      .DEPTH (LEDS_USED)
   ) u_colour_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_wide[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign scale_ctrl = '{mul_en: (state_ff == S_MUL), div_en: (state_ff == S_DIV), lit: lit_ff};

   alb_scaler u_scale_red (
      .clock  (clock),
      .ctrl   (scale_ctrl),
      .value  (rd_data.red),
      .bright (bright_ff),
      .level  (rsp_out_red)
   );

   alb_scaler u_scale_green (
      .clock  (clock),
      .ctrl   (scale_ctrl),
      .value  (rd_data.green),
      .bright (bright_ff),
      .level  (rsp_out_green)
   );

   alb_scaler u_scale_blue (
      .clock  (clock),
      .ctrl   (scale_ctrl),
      .value  (rd_data.blue),
      .bright (bright_ff),
      .level  (rsp_out_blue)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_number = led_num_ff;
   assign rsp_frame_last = last_ff;

   // A result is only offered from the output state
   a_rsp_in_out_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_OUT))
      else $error("result offered outside the output state");

   // Input is never taken while a result is pending
   a_no_accept_during_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> req_stall)
      else $error("input open while a result is pending");

   // The last LED's transfer reopens the input
   a_frame_end_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && last_ff) |=> !req_stall)
      else $error("input still closed after the final LED");

   // A block-end sample starts a frame
   a_block_end_starts_frame: assert property (@(posedge clock) disable iff (reset)
      (sample_xfer && req_block_end) |=> req_stall)
      else $error("block end did not start a frame");

endmodule

[bench/tb_audio_level_bar_meter.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the audio level bar meter: queued traffic, frame prediction, LED checks.
module tb_audio_level_bar_meter;

   localparam int LEDS_USED      = alb_pkg::LEDS_USED_DEF;
   localparam int LEDS_TOTAL     = alb_pkg::LEDS_TOTAL_DEF;
   localparam int MAX_BLOCK      = alb_pkg::MAX_BLOCK_DEF;
   localparam int FRAME_RAW      = (LEDS_USED > LEDS_TOTAL) ? LEDS_USED : LEDS_TOTAL;
   localparam int FRAME_LEN      = (FRAME_RAW > alb_pkg::RESULT_CAP) ?
                                   alb_pkg::RESULT_CAP : FRAME_RAW;
   localparam int COLOUR_W       = 3 * alb_pkg::COMP_W;
   localparam int SETTLE_CYCLES  = 4 * FRAME_LEN + 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 10;

   typedef struct {
      logic                               command;
      logic signed [alb_pkg::SAMPLE_W-1:0] sample_value;
      logic                               block_end;
      logic [alb_pkg::ENTRY_W-1:0]        entry_index;
      alb_pkg::colour_type                colour;
   } meter_item_type;

   typedef struct {
      logic [alb_pkg::LED_NUM_W-1:0] led_number;
      alb_pkg::colour_type           colour;
      logic                          frame_last;
   } led_drive_type;

   logic                                clock            = 1'b0;
   logic                                reset            = 1'b1;
   logic                                req_valid        = 1'b0;
   logic                                req_command      = alb_pkg::CMD_SAMPLE;
   logic signed [alb_pkg::SAMPLE_W-1:0] req_sample_value = '0;
   logic                                req_block_end    = 1'b0;
   logic [alb_pkg::ENTRY_W-1:0]         req_entry_index  = '0;
   logic [alb_pkg::COMP_W-1:0]          req_entry_red    = '0;
   logic [alb_pkg::COMP_W-1:0]          req_entry_green  = '0;
   logic [alb_pkg::COMP_W-1:0]          req_entry_blue   = '0;
   logic                                rsp_stall        = 1'b0;
   logic                                csr_valid        = 1'b0;
   logic [alb_pkg::CSR_IDX_W-1:0]       csr_index        = alb_pkg::CSR_METER_ENABLE;
   logic [alb_pkg::BRIGHT_W-1:0]        csr_data         = '0;

   logic                          req_stall;
   logic                          rsp_valid;
   logic [alb_pkg::LED_NUM_W-1:0] rsp_led_number;
   logic [alb_pkg::COMP_W-1:0]    rsp_out_red;
   logic [alb_pkg::COMP_W-1:0]    rsp_out_green;
   logic [alb_pkg::COMP_W-1:0]    rsp_out_blue;
   logic                          rsp_frame_last;
   logic                          csr_ready;

   // meter state as the block should hold it
   bit                  mdl_enable  = 1'b0;
   int unsigned         mdl_bright  = 100;
   longint unsigned     mag_sum     = 0;
   int unsigned         block_count = 0;
   alb_pkg::colour_type colour_mem [LEDS_USED] = '{default: '0};

   meter_item_type item_queue[$];
   led_drive_type  led_expect[$];
   meter_item_type cur_item;
   int unsigned    items_queued = 0;
   int unsigned    items_taken  = 0;
   int unsigned    error_count  = 0;
   int unsigned    send_gap     = 0;
   int unsigned    stall_left   = 0;
   int unsigned    quiet_cycles = 0;
   bit             no_idle      = 1'b0;

   audio_level_bar_meter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_sample_value (req_sample_value),
      .req_block_end    (req_block_end),
      .req_entry_index  (req_entry_index),
      .req_entry_red    (req_entry_red),
      .req_entry_green  (req_entry_green),
      .req_entry_blue   (req_entry_blue),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_led_number   (rsp_led_number),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_frame_last   (rsp_frame_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string field, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d want %0d", field, got, want));
   endtask

   function automatic logic [alb_pkg::COMP_W-1:0] scale_comp(
      input logic [alb_pkg::COMP_W-1:0] v,
      input int unsigned pct);
      int unsigned prod;
      prod = v * pct;
      return alb_pkg::COMP_W'(prod / 100);
   endfunction

   // Advance the meter by one accepted item and queue the frame it ends, if any.
   task automatic update_meter(input meter_item_type it);
      longint unsigned mean;
      longint unsigned level;
      logic [alb_pkg::SAMPLE_W:0] mag;
      led_drive_type d;
      if (it.command == alb_pkg::CMD_COLOUR) begin
         if (it.entry_index < LEDS_USED)
            colour_mem[it.entry_index] = it.colour;
      end else if (mdl_enable) begin
         if (block_count < MAX_BLOCK) begin
            mag = it.sample_value[alb_pkg::SAMPLE_W-1] ?
                  (17'h10000 - {1'b0, it.sample_value}) : {1'b0, it.sample_value};
            mag_sum += mag;
            block_count++;
         end
         if (it.block_end) begin
            mean  = (block_count != 0) ? mag_sum / block_count : 0;
            level = mean / alb_pkg::LEVEL_DIV;
            if (level > LEDS_USED)
               level = LEDS_USED;
            mag_sum     = 0;
            block_count = 0;
            for (int k = 0; k < FRAME_LEN; k++) begin
               d.led_number = k[alb_pkg::LED_NUM_W-1:0];
               d.colour     = '0;
               if (k < level && k < LEDS_USED) begin
                  d.colour.red   = scale_comp(colour_mem[k].red, mdl_bright);
                  d.colour.green = scale_comp(colour_mem[k].green, mdl_bright);
                  d.colour.blue  = scale_comp(colour_mem[k].blue, mdl_bright);
               end
               d.frame_last = (k == FRAME_LEN - 1);
               led_expect.push_back(d);
            end
         end
      end
   endtask

   task automatic push_sample(input logic signed [alb_pkg::SAMPLE_W-1:0] value,
                              input logic last);
      meter_item_type it;
      it.command      = alb_pkg::CMD_SAMPLE;
      it.sample_value = value;
      it.block_end    = last;
      it.entry_index  = alb_pkg::ENTRY_W'($urandom);
      it.colour       = COLOUR_W'($urandom);
      item_queue.push_back(it);
      items_queued++;
   endtask

   // Sample and flag fields carry junk on a colour write; the block must ignore them.
   task automatic push_colour(input logic [alb_pkg::ENTRY_W-1:0] idx,
                              input alb_pkg::colour_type c);
      meter_item_type it;
      it.command      = alb_pkg::CMD_COLOUR;
      it.sample_value = alb_pkg::SAMPLE_W'($urandom);
      it.block_end    = 1'($urandom);
      it.entry_index  = idx;
      it.colour       = c;
      item_queue.push_back(it);
      items_queued++;
   endtask

   function automatic logic signed [alb_pkg::SAMPLE_W-1:0] level_sample(
      input int unsigned lvl);
      int m;
      m = int'(lvl * alb_pkg::LEVEL_DIV + $urandom_range(0, alb_pkg::LEVEL_DIV - 1));
      if (m > 32767)
         m = 32767;
      if ($urandom_range(0, 1) != 0)
         m = -m;
      return alb_pkg::SAMPLE_W'(m);
   endfunction

   // One well-formed block near a target level, with some raw samples and colour writes mixed in.
   task automatic push_block(input int unsigned len, input int unsigned lvl);
      logic signed [alb_pkg::SAMPLE_W-1:0] v;
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0)
            push_colour(alb_pkg::ENTRY_W'($urandom), COLOUR_W'($urandom));
         v = ($urandom_range(0, 7) == 0) ? alb_pkg::SAMPLE_W'($urandom) : level_sample(lvl);
         push_sample(v, i == len - 1);
      end
   endtask

   task automatic write_csr(input logic [alb_pkg::CSR_IDX_W-1:0] idx,
                            input logic [alb_pkg::BRIGHT_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         alb_pkg::CSR_METER_ENABLE: mdl_enable = data[0];
         alb_pkg::CSR_BRIGHTNESS:
            mdl_bright = (data > alb_pkg::BRIGHT_MAX) ? alb_pkg::BRIGHT_MAX : data;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // Hold until every queued item is taken and every LED has come back, then let the block settle.
   task automatic drain();
      do @(posedge clock); while (items_taken != items_queued || led_expect.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sender: one transfer per accepted cycle, random gaps between items.
   always @(posedge clock) begin
      bit load;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            update_meter(cur_item);
            items_taken++;
         end
         if (!req_valid || !req_stall) begin
            load = 1'b0;
            if (send_gap > 0)
               send_gap--;
            else if (item_queue.size() != 0) begin
               if (!no_idle && $urandom_range(0, 5) == 0)
                  send_gap = $urandom_range(0, 3);
               else
                  load = 1'b1;
            end
            if (load) begin
               cur_item = item_queue.pop_front();
               req_command      <= cur_item.command;
               req_sample_value <= cur_item.sample_value;
               req_block_end    <= cur_item.block_end;
               req_entry_index  <= cur_item.entry_index;
               req_entry_red    <= cur_item.colour.red;
               req_entry_green  <= cur_item.colour.green;
               req_entry_blue   <= cur_item.colour.blue;
            end
            req_valid <= load;
         end
      end
   end

   // Receiver: random stall bursts, compare each LED transfer with the oldest expectation.
   always @(posedge clock) begin
      led_drive_type want;
      bit hold;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (led_expect.size() == 0)
               report_mismatch($sformatf("LED %0d with no frame pending", rsp_led_number));
            else begin
               want = led_expect.pop_front();
               check_field("led_number", rsp_led_number, want.led_number);
               check_field("out_red", rsp_out_red, want.colour.red);
               check_field("out_green", rsp_out_green, want.colour.green);
               check_field("out_blue", rsp_out_blue, want.colour.blue);
               check_field("frame_last", rsp_frame_last, want.frame_last);
            end
         end
         hold = 1'b0;
         if (stall_left > 0) begin
            stall_left--;
            hold = 1'b1;
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            hold = 1'b1;
         end
         rsp_stall <= hold;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_audio_level_bar_meter: FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned base;
      int unsigned len;
      logic [alb_pkg::BRIGHT_W-1:0] bright;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // meter off after reset: samples dropped, colour writes still land, out-of-range ones dropped
      push_sample(16'sh8000, 1'b1);
      push_colour(4'd11, 24'hFFFFFF);
      push_colour(4'd12, 24'h123456);
      push_colour(4'd15, 24'hFFFFFF);
      drain();

      write_csr(alb_pkg::CSR_METER_ENABLE, 7'h01);
      push_sample(16'sh0000, 1'b1);
      push_sample(16'sh8000, 1'b1);
      push_colour(4'd0, 24'hFF0000);
      push_colour(4'd1, 24'h00FF00);
      push_colour(4'd2, 24'h0000FF);
      for (int i = 3; i < 11; i++)
         push_colour(alb_pkg::ENTRY_W'(i), COLOUR_W'($urandom));
      push_sample(16'sh7FFF, 1'b1);
      push_sample(16'sd5000, 1'b0);
      push_sample(-16'sd5000, 1'b0);
      push_sample(16'sd5001, 1'b1);
      push_sample(16'sd999, 1'b1);
      push_sample(16'sd1000, 1'b1);
      drain();

      write_csr(alb_pkg::CSR_BRIGHTNESS, 7'd0);
      push_sample(16'sh7FFF, 1'b1);
      drain();
      write_csr(alb_pkg::CSR_BRIGHTNESS, 7'h7F);
      push_sample(16'sh8000, 1'b1);
      drain();
      write_csr(alb_pkg::CSR_BRIGHTNESS, 7'd1);
      push_sample(16'sd11500, 1'b1);
      drain();

      // turn the meter off in mid-block: the partial sum must survive
      write_csr(alb_pkg::CSR_BRIGHTNESS, 7'd99);
      push_sample(16'sd9000, 1'b0);
      push_sample(-16'sd9400, 1'b0);
      drain();
      write_csr(alb_pkg::CSR_METER_ENABLE, 7'h7E);
      for (int i = 0; i < 3; i++)
         push_sample(alb_pkg::SAMPLE_W'($urandom), 1'b1);
      push_colour(4'd4, COLOUR_W'($urandom));
      drain();
      write_csr(alb_pkg::CSR_METER_ENABLE, 7'h01);
      push_sample(16'sd9200, 1'b1);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == RANDOM_PHASES - 1)
            no_idle = 1'b1;
         case (p)
            0:       bright = 7'd100;
            1:       bright = 7'($urandom_range(101, 127));
            2:       bright = 7'd0;
            default: bright = 7'($urandom_range(0, 127));
         endcase
         write_csr(alb_pkg::CSR_BRIGHTNESS, bright);
         if (p == 3) begin
            write_csr(alb_pkg::CSR_METER_ENABLE, 7'($urandom_range(0, 63) * 2));
            for (int i = 0; i < 12; i++) begin
               if ($urandom_range(0, 1) != 0)
                  push_sample(alb_pkg::SAMPLE_W'($urandom), 1'($urandom));
               else
                  push_colour(alb_pkg::ENTRY_W'($urandom), COLOUR_W'($urandom));
            end
            drain();
         end
         write_csr(alb_pkg::CSR_METER_ENABLE, 7'($urandom_range(0, 63) * 2 + 1));
         base = items_queued;
         while (items_queued - base < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
               push_colour(alb_pkg::ENTRY_W'($urandom), COLOUR_W'($urandom));
            else begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
               push_block(len, $urandom_range(0, 13));
            end
         end
         drain();
      end

      if (error_count == 0 && led_expect.size() == 0)
         $display("tb_audio_level_bar_meter: PASS");
      else
         $display("tb_audio_level_bar_meter: FAIL");
      $finish;
   end

endmodule
